### hw/rtl/snq_pkg.sv
// ----------------------------------------------------------------------------
// snq_pkg
// shared types and constants for the named stack/queue manager
// ----------------------------------------------------------------------------
package snq_pkg;

    localparam int NumListsDef  = 16;
    localparam int PoolNodesDef = 256;
    localparam int KeyBits      = 64;
    localparam int ValueBits    = 32;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXISTS     = 3'd1,
        ST_NO_NAME    = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_POOL_FULL  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    // table write control
    typedef struct packed {
        logic create;
        logic update;
        logic kind;
    } t_tbl_cmd;

    // table lookup status
    typedef struct packed {
        logic hit;
        logic free_ok;
        logic kind;
    } t_tbl_hit;

endpackage

### hw/rtl/named_stack_queue_manager_core.sv
// ----------------------------------------------------------------------------
// named_stack_queue_manager_core
// named stacks and queues over a shared linked node pool
// ----------------------------------------------------------------------------
// lookup step (table match plus registered node memory read), then execute
//   step with write back; a new request is taken while the last one
//   executes; execute waits while a held result is stalled at the output
// reset: synchronous; clears table used bits, free list counters and state;
//   never-used nodes come from a fill counter, so no clearing pass is needed
// ----------------------------------------------------------------------------
module named_stack_queue_manager_core #(
    parameter int NUM_LISTS  = snq_pkg::NumListsDef,
    parameter int POOL_NODES = snq_pkg::PoolNodesDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [63:0]                         i_list_key,
    input  logic                                i_list_kind,
    input  logic signed [31:0]                  i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_status,
    output logic signed [31:0]                  o_popped_value,
    output logic                                o_value_valid
);
    import snq_pkg::*;

    localparam int IW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int AW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);

    // fsm
    t_state r_state, n_state;

    // captured request
    t_op                 r_op;
    logic [KeyBits-1:0]  r_key;
    logic                r_kind;
    logic [ValueBits-1:0] r_val;

    // lookup results held for the execute cycle
    t_tbl_hit            r_hit;
    logic [IW-1:0]       r_idx;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_tail;
    logic [CW-1:0]       r_cnt;

    // free list: recycled chain plus never-used fill counter
    logic [AW-1:0]       r_free_head, n_free_head;
    logic [CW-1:0]       r_rec_cnt, n_rec_cnt;
    logic [CW-1:0]       r_fresh, n_fresh;

    // output register
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [31:0]         r_popped, n_popped;
    logic                r_vvalid, n_vvalid;

    // table signals
    t_tbl_hit            tbl_hit;
    logic [IW-1:0]       tbl_match_idx;
    logic [IW-1:0]       tbl_free_idx;
    logic [AW-1:0]       tbl_head;
    logic [AW-1:0]       tbl_tail;
    logic [CW-1:0]       tbl_cnt;
    t_tbl_cmd            tbl_cmd;
    logic [AW-1:0]       wr_head;
    logic [AW-1:0]       wr_tail;
    logic [CW-1:0]       wr_cnt;

    // node memory signals
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [ValueBits-1:0] mem_rd_value;
    logic [AW-1:0]       mem_rd_link;
    logic                val_we;
    logic [AW-1:0]       val_addr;
    logic                lnk_we;
    logic [AW-1:0]       lnk_addr;
    logic [AW-1:0]       lnk_data;

    logic                accept;
    logic                exec_go;
    logic                pool_empty;
    logic [AW-1:0]       new_node;

    // execute may fire only when the output slot is free or draining
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || exec_go);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = accept ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_key  <= i_list_key[KeyBits-1:0];
            r_kind <= i_list_kind;
            r_val  <= i_push_value[ValueBits-1:0];
        end
    end

    snq_name_table #(
        .NUM_LISTS (NUM_LISTS),
        .IW        (IW),
        .AW        (AW),
        .CW        (CW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .o_hit       (tbl_hit),
        .o_match_idx (tbl_match_idx),
        .o_free_idx  (tbl_free_idx),
        .o_head      (tbl_head),
        .o_tail      (tbl_tail),
        .o_cnt       (tbl_cnt),
        .i_cmd       (tbl_cmd),
        .i_wr_idx    (r_idx),
        .i_wr_key    (r_key),
        .i_wr_head   (wr_head),
        .i_wr_tail   (wr_tail),
        .i_wr_cnt    (wr_cnt)
    );

    // lookup cycle: latch the table view and read the node to be touched
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_hit  <= tbl_hit;
            r_idx  <= tbl_hit.hit ? tbl_match_idx : tbl_free_idx;
            r_head <= tbl_head;
            r_tail <= tbl_tail;
            r_cnt  <= tbl_cnt;
        end
    end

    // pop reads the list head, push reads the next recycled node
    assign mem_rd_en   = (r_state == S_LOOK);
    assign mem_rd_addr = (r_op == OP_POP) ? tbl_head : r_free_head;

    snq_node_mem #(
        .POOL_NODES (POOL_NODES),
        .AW         (AW)
    ) u_nodes (
        .i_clk      (i_clk),
        .i_rd_en    (mem_rd_en),
        .i_rd_addr  (mem_rd_addr),
        .o_rd_value (mem_rd_value),
        .o_rd_link  (mem_rd_link),
        .i_val_we   (val_we),
        .i_val_addr (val_addr),
        .i_val_data (r_val),
        .i_lnk_we   (lnk_we),
        .i_lnk_addr (lnk_addr),
        .i_lnk_data (lnk_data)
    );

    assign pool_empty = (r_rec_cnt == '0) && (r_fresh == CW'(POOL_NODES));
    assign new_node   = (r_rec_cnt != '0) ? r_free_head : r_fresh[AW-1:0];

    // execute cycle
    always_comb begin
        n_status    = ST_OK;
        n_popped    = '0;
        n_vvalid    = 1'b0;
        n_free_head = r_free_head;
        n_rec_cnt   = r_rec_cnt;
        n_fresh     = r_fresh;
        tbl_cmd     = '0;
        tbl_cmd.kind = r_kind;
        wr_head     = r_head;
        wr_tail     = r_tail;
        wr_cnt      = r_cnt;
        val_we      = 1'b0;
        val_addr    = new_node;
        lnk_we      = 1'b0;
        lnk_addr    = new_node;
        lnk_data    = r_head;
        case (r_op)
            OP_CREATE: begin
                if (r_hit.hit) begin
                    n_status = ST_EXISTS;
                end else if (!r_hit.free_ok) begin
                    n_status = ST_TABLE_FULL;
                end else begin
                    tbl_cmd.create = exec_go;
                end
            end
            OP_PUSH: begin
                if (!r_hit.hit) begin
                    n_status = ST_NO_NAME;
                end else if (pool_empty) begin
                    n_status = ST_POOL_FULL;
                end else begin
                    // take a recycled node first, else a never-used one
                    if (r_rec_cnt != '0) begin
                        n_free_head = mem_rd_link;
                        n_rec_cnt   = r_rec_cnt - 1'b1;
                    end else begin
                        n_fresh = r_fresh + 1'b1;
                    end
                    val_we         = exec_go;
                    tbl_cmd.update = exec_go;
                    wr_cnt         = r_cnt + 1'b1;
                    if (!r_hit.kind) begin
                        // stack: link in front of the head
                        lnk_we   = exec_go;
                        lnk_addr = new_node;
                        lnk_data = r_head;
                        wr_head  = new_node;
                        wr_tail  = (r_cnt == '0) ? new_node : r_tail;
                    end else begin
                        // queue: append behind the tail; a lone node needs no link
                        lnk_we   = exec_go && (r_cnt != '0);
                        lnk_addr = r_tail;
                        lnk_data = new_node;
                        wr_head  = (r_cnt == '0) ? new_node : r_head;
                        wr_tail  = new_node;
                    end
                end
            end
            OP_POP: begin
                if (!r_hit.hit) begin
                    n_status = ST_NO_NAME;
                end else if (r_cnt == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped       = 32'(mem_rd_value);
                    n_vvalid       = 1'b1;
                    tbl_cmd.update = exec_go;
                    wr_head        = mem_rd_link;
                    wr_cnt         = r_cnt - 1'b1;
                    // popped node goes on the recycled chain
                    lnk_we         = exec_go;
                    lnk_addr       = r_head;
                    lnk_data       = r_free_head;
                    n_free_head    = r_head;
                    n_rec_cnt      = r_rec_cnt + 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_rec_cnt   <= '0;
            r_fresh     <= '0;
        end else if (exec_go) begin
            r_free_head <= n_free_head;
            r_rec_cnt   <= n_rec_cnt;
            r_fresh     <= n_fresh;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status <= n_status;
            r_popped <= n_popped;
            r_vvalid <= n_vvalid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_value_valid  = r_vvalid;

`ifndef ASSERT_OFF
    // recycled nodes can only come from nodes handed out before
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= r_fresh)
        else $error("recycled count exceeds nodes handed out");

    // a popped value only comes with ok status
    a_vvalid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_valid) |-> (o_status == ST_OK))
        else $error("value valid without ok status");

    // a new result is loaded only out of the execute cycle
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared outside execute");

    // requests are taken only when idle or while finishing one
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ((r_state == S_IDLE) || exec_go))
        else $error("request accepted in busy state");
`endif

endmodule

### hw/rtl/snq_node_mem.sv
// ----------------------------------------------------------------------------
// snq_node_mem
// node pool storage: value and link memories, one read address shared
// ----------------------------------------------------------------------------
module snq_node_mem #(
    parameter int POOL_NODES = snq_pkg::PoolNodesDef,
    parameter int AW         = $clog2(POOL_NODES)
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [AW-1:0]                  i_rd_addr,
    output logic [snq_pkg::ValueBits-1:0]  o_rd_value,
    output logic [AW-1:0]                  o_rd_link,
    input  logic                           i_val_we,
    input  logic [AW-1:0]                  i_val_addr,
    input  logic [snq_pkg::ValueBits-1:0]  i_val_data,
    input  logic                           i_lnk_we,
    input  logic [AW-1:0]                  i_lnk_addr,
    input  logic [AW-1:0]                  i_lnk_data
);
    import snq_pkg::*;

    logic [ValueBits-1:0] r_value_mem [POOL_NODES];
    logic [AW-1:0]        r_link_mem  [POOL_NODES];

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            r_value_mem[i_val_addr] <= i_val_data;
        end
        if (i_rd_en) begin
            o_rd_value <= r_value_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lnk_we) begin
            r_link_mem[i_lnk_addr] <= i_lnk_data;
        end
        if (i_rd_en) begin
            o_rd_link <= r_link_mem[i_rd_addr];
        end
    end

endmodule

### hw/rtl/snq_name_table.sv
// ----------------------------------------------------------------------------
// snq_name_table
// list name table with parallel key match and per-list pointers
// ----------------------------------------------------------------------------
module snq_name_table #(
    parameter int NUM_LISTS = snq_pkg::NumListsDef,
    parameter int IW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
    parameter int AW        = 8,
    parameter int CW        = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [snq_pkg::KeyBits-1:0]  i_key,
    output snq_pkg::t_tbl_hit            o_hit,
    output logic [IW-1:0]                o_match_idx,
    output logic [IW-1:0]                o_free_idx,
    output logic [AW-1:0]                o_head,
    output logic [AW-1:0]                o_tail,
    output logic [CW-1:0]                o_cnt,
    input  snq_pkg::t_tbl_cmd            i_cmd,
    input  logic [IW-1:0]                i_wr_idx,
    input  logic [snq_pkg::KeyBits-1:0]  i_wr_key,
    input  logic [AW-1:0]                i_wr_head,
    input  logic [AW-1:0]                i_wr_tail,
    input  logic [CW-1:0]                i_wr_cnt
);
    import snq_pkg::*;

    logic                r_used [NUM_LISTS];
    logic [KeyBits-1:0]  r_key  [NUM_LISTS];
    logic                r_kind [NUM_LISTS];
    logic [AW-1:0]       r_head [NUM_LISTS];
    logic [AW-1:0]       r_tail [NUM_LISTS];
    logic [CW-1:0]       r_cnt  [NUM_LISTS];

    logic                hit;
    logic                free_ok;
    logic [IW-1:0]       match_idx;
    logic [IW-1:0]       free_idx;

    // descending scan leaves the lowest index
    always_comb begin
        hit       = 1'b0;
        free_ok   = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (r_used[i] && (r_key[i] == i_key)) begin
                hit       = 1'b1;
                match_idx = IW'(i);
            end
            if (!r_used[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign o_hit.hit     = hit;
    assign o_hit.free_ok = free_ok;
    assign o_hit.kind    = r_kind[match_idx];
    assign o_match_idx   = match_idx;
    assign o_free_idx    = free_idx;
    assign o_head        = r_head[match_idx];
    assign o_tail        = r_tail[match_idx];
    assign o_cnt         = r_cnt[match_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else if (i_cmd.create) begin
            r_used[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            r_key[i_wr_idx]  <= i_wr_key;
            r_kind[i_wr_idx] <= i_cmd.kind;
            r_head[i_wr_idx] <= '0;
            r_tail[i_wr_idx] <= '0;
            r_cnt[i_wr_idx]  <= '0;
        end else if (i_cmd.update) begin
            r_head[i_wr_idx] <= i_wr_head;
            r_tail[i_wr_idx] <= i_wr_tail;
            r_cnt[i_wr_idx]  <= i_wr_cnt;
        end
    end

endmodule

### tb/tb_named_stack_queue_manager_core.sv
// ----------------------------------------------------------------------------
// tb_named_stack_queue_manager_core
// drives create, push and pop requests with random idling on both sides and
// compares every result against a behavioral model of the list manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_named_stack_queue_manager_core;
    import snq_pkg::*;

    localparam int NLISTS = NumListsDef;
    localparam int NNODES = PoolNodesDef;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_op = OP_NONE;
    logic [63:0]        i_list_key = '0;
    logic               i_list_kind = 1'b0;
    logic signed [31:0] i_push_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_popped_value;
    logic               o_value_valid;

    named_stack_queue_manager_core dut (.*);

    always #5 i_clk = ~i_clk;

    // one expected result per request
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic        vld;
    } t_outcome;

    t_outcome pending_q[$];

    // model state: name table and linked node pool
    logic        tbl_used [NLISTS];
    logic [63:0] tbl_key  [NLISTS];
    logic        tbl_queue[NLISTS];
    int          tbl_head [NLISTS];
    int          tbl_tail [NLISTS];
    int          tbl_count[NLISTS];
    logic [31:0] pool_val [NNODES];
    int          pool_next[NNODES];
    int          free_top;
    int          free_left;

    int   mismatches = 0;
    int   results_seen = 0;
    int   pops_seen = 0;
    int   cycles = 0;
    int   send_idle_pct = 35;
    int   recv_idle_pct = 83;
    logic sending = 1'b0;

    // live keys, used to aim random requests at existing lists
    logic [63:0] known_keys[$];

    function automatic int find_list(logic [63:0] key);
        for (int i = 0; i < NLISTS; i++)
            if (tbl_used[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic t_outcome apply_request(logic [1:0] op, logic [63:0] key,
                                               logic kind, logic [31:0] val);
        t_outcome r;
        int e;
        int n;
        r = '{status: ST_OK, value: '0, vld: 1'b0};
        e = find_list(key);
        case (op)
            OP_CREATE: begin
                if (e >= 0) begin
                    r.status = ST_EXISTS;
                end else begin
                    r.status = ST_TABLE_FULL;
                    for (int i = 0; i < NLISTS; i++) begin
                        if (!tbl_used[i]) begin
                            tbl_used[i] = 1'b1;
                            tbl_key[i] = key;
                            tbl_queue[i] = kind;
                            tbl_head[i] = 0;
                            tbl_tail[i] = 0;
                            tbl_count[i] = 0;
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_PUSH: begin
                if (e < 0) r.status = ST_NO_NAME;
                else if (free_left == 0) r.status = ST_POOL_FULL;
                else begin
                    n = free_top;
                    free_top = pool_next[n];
                    free_left--;
                    pool_val[n] = val;
                    if (!tbl_queue[e]) begin
                        pool_next[n] = tbl_head[e];
                        tbl_head[e] = n;
                        if (tbl_count[e] == 0) tbl_tail[e] = n;
                    end else begin
                        pool_next[n] = 0;
                        if (tbl_count[e] == 0) tbl_head[e] = n;
                        else pool_next[tbl_tail[e]] = n;
                        tbl_tail[e] = n;
                    end
                    tbl_count[e]++;
                end
            end
            OP_POP: begin
                if (e < 0) r.status = ST_NO_NAME;
                else if (tbl_count[e] == 0) r.status = ST_EMPTY;
                else begin
                    n = tbl_head[e];
                    r.value = pool_val[n];
                    r.vld = 1'b1;
                    tbl_head[e] = pool_next[n];
                    tbl_count[e]--;
                    pool_next[n] = free_top;
                    free_top = n;
                    free_left++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one request; typed_ok set means the row's expectation is typed in
    // valid stays high after acceptance only while the next request follows
    // in the same time step; every idle cycle drops it
    task automatic send_request(logic [1:0] op, logic [63:0] key, logic kind,
                                logic [31:0] val, bit typed_ok = 0,
                                t_outcome typed = '0);
        t_outcome r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_list_key   <= key;
        i_list_kind  <= kind;
        i_push_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // request accepted at this edge
        r = apply_request(op, key, kind, val);
        if (typed_ok && r != typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("typed row: op %0d status exp %0d model %0d, value exp %h model %h",
                         op, typed.status, r.status, typed.value, r.value);
        end
        pending_q.insert(pending_q.size(), r);
        if (op == OP_CREATE && r.status == ST_OK) known_keys.insert(known_keys.size(), key);
    endtask

    // receiver: random stall, compare on accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_outcome got;
                got = '{status: o_status, value: o_popped_value, vld: o_value_valid};
                results_seen++;
                if (got.vld) pops_seen++;
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    t_outcome want;
                    want = pending_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, value exp %h got %h, valid exp %0d got %0d",
                                     want.status, got.status, want.value, got.value,
                                     want.vld, got.vld);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[named_stack_queue_manager_core] ERROR");
            $finish;
        end
    end

    // directed rows
    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic        kind;
        logic [31:0] val;
        bit          typed_ok;
        t_outcome    typed;
    } t_row;

    localparam logic [63:0] KMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    t_row rows[$];

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        // mostly live names, sometimes a random or near-miss one
        int p;
        p = $urandom_range(99);
        if (known_keys.size() > 0 && p < 85)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if (known_keys.size() > 0 && p < 92)
            return known_keys[$urandom_range(known_keys.size() - 1)] ^ (64'd1 << $urandom_range(63));
        return rand_key();
    endfunction

    task automatic random_phase(int count, int push_pct, int pop_pct);
        int p;
        logic [1:0] op;
        for (int k = 0; k < count; k++) begin
            p = $urandom_range(99);
            if (p < push_pct) op = OP_PUSH;
            else if (p < push_pct + pop_pct) op = OP_POP;
            else if (p < 97) op = OP_CREATE;
            else op = OP_NONE;
            send_request(op, (op == OP_CREATE && $urandom_range(3) != 0) ? rand_key() : pick_key(),
                         $urandom_range(1), $urandom());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_outcome ok0;
        ok0 = '{status: ST_OK, value: '0, vld: 1'b0};
        for (int i = 0; i < NLISTS; i++) begin
            tbl_used[i] = 0; tbl_key[i] = '0; tbl_queue[i] = 0;
            tbl_head[i] = 0; tbl_tail[i] = 0; tbl_count[i] = 0;
        end
        for (int i = 0; i < NNODES; i++) begin
            pool_val[i] = '0;
            pool_next[i] = (i + 1 < NNODES) ? i + 1 : 0;
        end
        free_top = 0;
        free_left = NNODES;

        // create, push and pop on missing names, extreme keys, both kinds, error codes
        rows = '{
            '{OP_POP,    KMAX,  1'b0, 32'h0,          1, '{ST_NO_NAME, 32'h0, 1'b0}},
            '{OP_PUSH,   64'h0, 1'b0, 32'h7FFF_FFFF,  1, '{ST_NO_NAME, 32'h0, 1'b0}},
            '{OP_NONE,   64'h0, 1'b1, 32'hFFFF_FFFF,  1, ok0},
            '{OP_CREATE, 64'h0, 1'b0, 32'h0,          1, ok0},
            '{OP_CREATE, 64'h0, 1'b1, 32'h0,          1, '{ST_EXISTS, 32'h0, 1'b0}},
            '{OP_CREATE, KMAX,  1'b1, 32'h0,          1, ok0},
            '{OP_POP,    64'h0, 1'b0, 32'h0,          1, '{ST_EMPTY, 32'h0, 1'b0}},
            '{OP_POP,    KMAX,  1'b0, 32'h0,          1, '{ST_EMPTY, 32'h0, 1'b0}},
            '{OP_PUSH,   64'h0, 1'b0, 32'h8000_0000,  0, ok0},
            '{OP_PUSH,   64'h0, 1'b0, 32'h7FFF_FFFF,  0, ok0},
            '{OP_PUSH,   KMAX,  1'b0, 32'hFFFF_FFFF,  0, ok0},
            '{OP_PUSH,   KMAX,  1'b1, 32'h0000_0000,  0, ok0},
            '{OP_POP,    64'h0, 1'b0, 32'h0,          0, ok0},
            '{OP_POP,    KMAX,  1'b0, 32'h0,          0, ok0},
            '{OP_POP,    64'h0, 1'b0, 32'h0,          0, ok0},
            '{OP_POP,    KMAX,  1'b0, 32'h0,          0, ok0},
            '{OP_POP,    64'h0, 1'b0, 32'h0,          1, '{ST_EMPTY, 32'h0, 1'b0}},
            '{OP_PUSH,   64'h1, 1'b0, 32'h5A5A_A5A5,  1, '{ST_NO_NAME, 32'h0, 1'b0}}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_request(rows[i].op, rows[i].key, rows[i].kind, rows[i].val,
                         rows[i].typed_ok, rows[i].typed);

        // fill the table to hit table full
        for (int i = 0; i < NLISTS; i++) send_request(OP_CREATE, rand_key(), i[0], '0);

        // hold off until the pipeline is empty
        drain();

        // push-heavy: presses on the pool
        random_phase(330, 80, 12);
        send_idle_pct = 83; recv_idle_pct = 35;
        // pop-heavy: empties lists again
        random_phase(120, 15, 80);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(100, 45, 45);

        drain();
        repeat (10) @(posedge i_clk);
        if (pending_q.size() != 0) mismatches++;

        $display("run covered %0d results, %0d successful pops, a full table and a push-heavy pool",
                 results_seen, pops_seen);
        if (mismatches == 0) begin
            $display("[named_stack_queue_manager_core] OK");
        end else begin
            $display("[named_stack_queue_manager_core] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/snq_pkg.sv
hw/rtl/snq_node_mem.sv
hw/rtl/snq_name_table.sv
hw/rtl/named_stack_queue_manager_core.sv
tb/tb_named_stack_queue_manager_core.sv
